### rtl/core/stla_pkg.sv
// shared types and constants of the strip to list assembler
`default_nettype none

package stla_pkg;

  localparam int unsigned IDX_W = 32;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_RESTART_VALUE = 1'b0,
    CFG_LIST_MODE     = 1'b1
  } cfg_index_t;

  typedef logic [IDX_W-1:0] vidx_t;

  typedef struct packed {
    vidx_t corner_a;
    vidx_t corner_b;
    vidx_t corner_c;
    logic  from_final;
  } tri_t;

endpackage

`default_nettype wire

### rtl/core/stla_core.sv
// configuration registers, index window state and triangle assembly
`default_nettype none

module stla_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire logic                step,
  input  wire stla_pkg::vidx_t     vertex_index,
  input  wire logic                end_of_list,
  output logic                     emit,
  output stla_pkg::tri_t           tri_out
);
  import stla_pkg::*;

  vidx_t      restart_value_r;
  logic       list_mode_r;
  vidx_t      older_r, older_nxt;
  vidx_t      newer_r, newer_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       odd_r, odd_nxt;

  logic is_restart;
  logic full;
  logic swap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_value_r <= '1;
      list_mode_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_RESTART_VALUE: restart_value_r <= cfg_data[IDX_W-1:0];
        CFG_LIST_MODE:     list_mode_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign is_restart = !list_mode_r && (vertex_index == restart_value_r);
  assign full       = fill_r[1];
  assign swap       = !list_mode_r && odd_r;
  assign emit       = !is_restart && full;

  always_comb begin
    tri_out.corner_a   = swap ? newer_r : older_r;
    tri_out.corner_b   = swap ? older_r : newer_r;
    tri_out.corner_c   = vertex_index;
    tri_out.from_final = end_of_list;
  end

  always_comb begin
    older_nxt = older_r;
    newer_nxt = newer_r;
    fill_nxt  = fill_r;
    odd_nxt   = odd_r;
    if (end_of_list) begin
      older_nxt = '0;
      newer_nxt = '0;
      fill_nxt  = 2'd0;
      odd_nxt   = 1'b0;
    end else if (is_restart) begin
      fill_nxt = 2'd0;
    end else begin
      older_nxt = newer_r;
      newer_nxt = vertex_index;
      if (!full) begin
        fill_nxt = fill_r + 2'd1;
      end else if (list_mode_r) begin
        fill_nxt = 2'd0;
      end else begin
        odd_nxt = !odd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= '0;
      newer_r <= '0;
      fill_r  <= 2'd0;
      odd_r   <= 1'b0;
    end else if (step) begin
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      fill_r  <= fill_nxt;
      odd_r   <= odd_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/stla_out_reg.sv
// result register with valid/ready handshake
`default_nettype none

module stla_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire stla_pkg::tri_t   tri_in,
  output logic                  can_load,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output stla_pkg::tri_t        tri_q
);
  import stla_pkg::*;

  logic  valid_r, valid_nxt;
  tri_t  data_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= tri_in;
    end
  end

  assign out_valid = valid_r;
  assign tri_q     = data_r;

endmodule

`default_nettype wire

### rtl/core/strip_to_list_assembler.sv
// top level of the strip to list assembler
//
//   channel   direction   signals
//   in_       input       in_valid, in_ready, in_vertex_index, in_end_of_list
//   out_      output      out_valid, out_ready, out_corner_a/b/c, out_from_final
//   cfg_      input       cfg_we, cfg_index, cfg_data (write only)
//
// one index is taken per cycle while in_ready is high; a triangle appears
// the cycle after its completing index transfers, in a single result register
// in_ready is low only while that register is full and out_ready is low
// reset (synchronous, active low) clears the index window, winding parity and
// output valid, sets the restart value to all ones and selects strip mode
`default_nettype none

module strip_to_list_assembler (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [31:0]         in_vertex_index,
  input  wire logic                in_end_of_list,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [31:0]              out_corner_a,
  output logic [31:0]              out_corner_b,
  output logic [31:0]              out_corner_c,
  output logic                     out_from_final
);
  import stla_pkg::*;

  logic in_xfer;
  logic emit;
  logic can_load;
  tri_t tri_c;
  tri_t tri_q;

  assign in_ready = can_load;
  assign in_xfer  = in_valid && can_load;

  stla_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .step         (in_xfer),
    .vertex_index (in_vertex_index),
    .end_of_list  (in_end_of_list),
    .emit         (emit),
    .tri_out      (tri_c)
  );

  stla_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_xfer && emit),
    .tri_in    (tri_c),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tri_q     (tri_q)
  );

  assign out_corner_a   = tri_q.corner_a;
  assign out_corner_b   = tri_q.corner_b;
  assign out_corner_c   = tri_q.corner_c;
  assign out_from_final = tri_q.from_final;

endmodule

`default_nettype wire
